// File: rtl/mpim_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mpim_pkg;

   // width of a linear index and of every configuration word
   localparam int IDX_W = 48;

   // divider quotient bits resolved per pipeline stage
   localparam int DIV_STEPS = 4;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANK_IN_USE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_DIMS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_DIMS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEADING_PADS = 3'd4;

   localparam int RANK_W = 3;

   // per-dimension control; the user keeps it fixed while items flow, the block does not enforce this
   typedef struct packed {
      logic mode;
      logic active;
   } dim_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/mpim_if.sv
`timescale 1ns / 1ps
`default_nettype none

// request word: one output index
interface mpim_req_if;
   logic                       valid;
   logic                       ready;
   logic [mpim_pkg::IDX_W-1:0] out_index;
   modport source (output valid, output out_index, input ready);
   modport sink   (input valid, input out_index, output ready);
endinterface

// response word: one source index
interface mpim_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [mpim_pkg::IDX_W-1:0] source_index;
   modport source (output valid, output source_index, input ready);
   modport sink   (input valid, input source_index, output ready);
endinterface

// configuration write word
interface mpim_csr_if;
   logic                           valid;
   logic                           ready;
   logic [mpim_pkg::CSR_IDX_W-1:0] index;
   logic [mpim_pkg::IDX_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/mpim_dim.sv
`timescale 1ns / 1ps
`default_nettype none

// One dimension: pipelined divide of the running index by the output size,
// mirror of the coordinate, then accumulation into the source offset.
module mpim_dim #(
   parameter int DIM_BITS = 12
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         en,
   input  wire mpim_pkg::dim_ctrl_type ctrl,
   input  wire [DIM_BITS-1:0]          osz,
   input  wire [DIM_BITS-1:0]          isz,
   input  wire [DIM_BITS-1:0]          pad,
   input  wire                         vld_in,
   input  wire [mpim_pkg::IDX_W-1:0]   idx_in,
   input  wire [mpim_pkg::IDX_W-1:0]   res_in,
   input  wire [mpim_pkg::IDX_W-1:0]   str_in,
   output logic                        vld_out,
   output logic [mpim_pkg::IDX_W-1:0]  idx_out,
   output logic [mpim_pkg::IDX_W-1:0]  res_out,
   output logic [mpim_pkg::IDX_W-1:0]  str_out
);

   localparam int W  = mpim_pkg::IDX_W;
   localparam int K  = mpim_pkg::DIV_STEPS;
   localparam int NS = W / K;
   localparam int CW = DIM_BITS + 3;

   logic div_on;
   assign div_on = ctrl.active && (osz != '0);

   // stage views: entry 0 is the module input
   logic                stg_vld [0:NS];
   logic [W-1:0]        stg_q   [0:NS];
   logic [DIM_BITS-1:0] stg_rem [0:NS];
   logic [W-1:0]        stg_res [0:NS];
   logic [W-1:0]        stg_str [0:NS];

   logic                vld_ff [0:NS-1];
   logic [W-1:0]        q_ff   [0:NS-1];
   logic [DIM_BITS-1:0] rem_ff [0:NS-1];
   logic [W-1:0]        res_ff [0:NS-1];
   logic [W-1:0]        str_ff [0:NS-1];

   assign stg_vld[0] = vld_in;
   assign stg_q[0]   = idx_in;
   assign stg_rem[0] = '0;
   assign stg_res[0] = res_in;
   assign stg_str[0] = str_in;

   genvar s;
   generate
      for (s = 0; s < NS; s++) begin : g_div
         logic [W-1:0]        q_in;
         logic [DIM_BITS-1:0] rem_in;

         // K restoring division steps; with no divide the word rotates back
         always_comb begin
            logic [DIM_BITS:0] t;
            logic              qb;
            t      = '0;
            q_in   = stg_q[s];
            rem_in = stg_rem[s];
            for (int k = 0; k < K; k++) begin
               qb = q_in[W-1];
               if (div_on) begin
                  t = {rem_in, qb};
                  if (t >= {1'b0, osz}) begin
                     t      = t - {1'b0, osz};
                     rem_in = t[DIM_BITS-1:0];
                     q_in   = {q_in[W-2:0], 1'b1};
                  end else begin
                     rem_in = t[DIM_BITS-1:0];
                     q_in   = {q_in[W-2:0], 1'b0};
                  end
               end else begin
                  q_in = {q_in[W-2:0], qb};
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[s] <= 1'b0;
            end else if (en) begin
               vld_ff[s] <= stg_vld[s];
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               q_ff[s]   <= q_in;
               rem_ff[s] <= rem_in;
               res_ff[s] <= stg_res[s];
               str_ff[s] <= stg_str[s];
            end
         end

         assign stg_vld[s+1] = vld_ff[s];
         assign stg_q[s+1]   = q_ff[s];
         assign stg_rem[s+1] = rem_ff[s];
         assign stg_res[s+1] = res_ff[s];
         assign stg_str[s+1] = str_ff[s];
      end
   endgenerate

   // mirror and clamp the coordinate
   logic [DIM_BITS-1:0] crd_in;
   always_comb begin
      logic signed [CW-1:0] cv;
      logic signed [CW-1:0] iv;
      logic signed [CW-1:0] m;
      cv = $signed({3'b000, stg_rem[NS]}) - $signed({3'b000, pad});
      iv = $signed({3'b000, isz});
      if (cv < 0) begin
         m = ctrl.mode ? (-cv - CW'(1)) : -cv;
      end else if (cv >= iv) begin
         m = ctrl.mode ? (iv + iv - CW'(1) - cv) : (iv + iv - CW'(2) - cv);
      end else begin
         m = cv;
      end
      if (m > iv - CW'(1)) begin
         m = iv - CW'(1);
      end
      if (m < 0) begin
         m = '0;
      end
      crd_in = m[DIM_BITS-1:0];
   end

   logic                vm_ff;
   logic [DIM_BITS-1:0] crd_ff;
   logic [W-1:0]        qm_ff, resm_ff, strm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
      end else if (en) begin
         vm_ff <= stg_vld[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         crd_ff  <= crd_in;
         qm_ff   <= stg_q[NS];
         resm_ff <= stg_res[NS];
         strm_ff <= stg_str[NS];
      end
   end

   // products: coordinate times stride, next stride
   logic [W+DIM_BITS-1:0] prod_full, strn_full;
   logic [W-1:0]          prod_in, strn_in;
   assign prod_full = strm_ff * crd_ff;
   assign strn_full = strm_ff * isz;
   assign prod_in   = ctrl.active ? prod_full[W-1:0] : '0;
   assign strn_in   = ctrl.active ? strn_full[W-1:0] : strm_ff;

   logic         vp_ff;
   logic [W-1:0] prod_ff, strp_ff, qp_ff, resp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
      end else if (en) begin
         vp_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         strp_ff <= strn_in;
         qp_ff   <= qm_ff;
         resp_ff <= resm_ff;
      end
   end

   // accumulate
   logic         va_ff;
   logic [W-1:0] resa_ff, stra_ff, qa_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= vp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         resa_ff <= resp_ff + prod_ff;
         stra_ff <= strp_ff;
         qa_ff   <= qp_ff;
      end
   end

   assign vld_out = va_ff;
   assign idx_out = qa_ff;
   assign res_out = resa_ff;
   assign str_out = stra_ff;

endmodule

`default_nettype wire

// File: rtl/mirror_pad_index_map.sv
`timescale 1ns / 1ps
`default_nettype none

// Mirror-pad address generator.
// req_word carries an output-tensor linear index (out_index); rsp_word
// returns the row-major input index to copy from (source_index). Both are
// valid/ready channels; a word moves when valid and ready are high.
// csr_word writes the configuration registers by index and is always ready;
// write it only while no request is in flight.
// Each dimension takes DIM_BITS-independent 48/4 = 12 divider stages plus
// mirror, multiply and accumulate stages. One word is accepted every cycle
// while the pipeline advances; the throughput is set by the shared pipeline
// advance, one stage per cycle.
// When the receiver holds rsp_word.ready low with a result waiting, the
// whole pipeline freezes and req_word.ready drops; nothing is lost.
// Reset (synchronous) empties the pipeline and restores the registers:
// reflect mode, rank 1, all sizes 1, no padding.
module mirror_pad_index_map #(
   parameter int MAX_RANK = 4,
   parameter int DIM_BITS = 12
) (
   input  wire clock,
   input  wire reset,
   mpim_req_if.sink   req_word,
   mpim_rsp_if.source rsp_word,
   mpim_csr_if.sink   csr_word
);

   localparam int W     = mpim_pkg::IDX_W;
   localparam int EXT_W = W + MAX_RANK * DIM_BITS;

   function automatic logic [W-1:0] ones_dims();
      logic [EXT_W-1:0] v;
      v = '0;
      for (int d = 0; d < MAX_RANK; d++) begin
         v[d*DIM_BITS] = 1'b1;
      end
      return v[W-1:0];
   endfunction

   localparam logic [W-1:0] DIMS_RST = ones_dims();

   // configuration registers
   logic                          mode_ff;
   logic [mpim_pkg::RANK_W-1:0]   rank_ff;
   logic [W-1:0]                  idim_ff, odim_ff, pads_ff;

   assign csr_word.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         rank_ff <= mpim_pkg::RANK_W'(1);
         idim_ff <= DIMS_RST;
         odim_ff <= DIMS_RST;
         pads_ff <= '0;
      end else if (csr_word.valid) begin
         case (csr_word.index)
            mpim_pkg::CSR_MIRROR_MODE:  mode_ff <= csr_word.data[0];
            mpim_pkg::CSR_RANK_IN_USE:  rank_ff <= csr_word.data[mpim_pkg::RANK_W-1:0];
            mpim_pkg::CSR_INPUT_DIMS:   idim_ff <= csr_word.data;
            mpim_pkg::CSR_OUTPUT_DIMS:  odim_ff <= csr_word.data;
            mpim_pkg::CSR_LEADING_PADS: pads_ff <= csr_word.data;
            default: ;
         endcase
      end
   end

   // fields beyond the 48 register bits read as zero
   logic [EXT_W-1:0] idim_ext, odim_ext, pads_ext;
   assign idim_ext = {{(EXT_W-W){1'b0}}, idim_ff};
   assign odim_ext = {{(EXT_W-W){1'b0}}, odim_ff};
   assign pads_ext = {{(EXT_W-W){1'b0}}, pads_ff};

   // rank clamped to 1..MAX_RANK
   logic [mpim_pkg::RANK_W:0] rank_c;
   always_comb begin
      rank_c = {1'b0, rank_ff};
      if (rank_c == '0) begin
         rank_c = (mpim_pkg::RANK_W+1)'(1);
      end
      if (rank_c > (mpim_pkg::RANK_W+1)'(MAX_RANK)) begin
         rank_c = (mpim_pkg::RANK_W+1)'(MAX_RANK);
      end
   end

   // pipeline advances unless a finished result is held
   logic en;
   logic last_vld;
   assign en = !last_vld || rsp_word.ready;
   assign req_word.ready = en;

   // chain: position j handles slot MAX_RANK-1-j, fastest first
   logic         ch_vld [0:MAX_RANK];
   logic [W-1:0] ch_idx [0:MAX_RANK];
   logic [W-1:0] ch_res [0:MAX_RANK];
   logic [W-1:0] ch_str [0:MAX_RANK];

   assign ch_vld[0] = req_word.valid;
   assign ch_idx[0] = req_word.out_index;
   assign ch_res[0] = '0;
   assign ch_str[0] = W'(1);

   genvar j;
   generate
      for (j = 0; j < MAX_RANK; j++) begin : g_dim
         localparam int SLOT = MAX_RANK - 1 - j;
         mpim_pkg::dim_ctrl_type ctrl;
         assign ctrl.mode   = mode_ff;
         assign ctrl.active = ((mpim_pkg::RANK_W+1)'(j) < rank_c);

         mpim_dim #(
            .DIM_BITS(DIM_BITS)
         ) u_dim (
            .clock   (clock),
            .reset   (reset),
            .en      (en),
            .ctrl    (ctrl),
            .osz     (odim_ext[SLOT*DIM_BITS +: DIM_BITS]),
            .isz     (idim_ext[SLOT*DIM_BITS +: DIM_BITS]),
            .pad     (pads_ext[SLOT*DIM_BITS +: DIM_BITS]),
            .vld_in  (ch_vld[j]),
            .idx_in  (ch_idx[j]),
            .res_in  (ch_res[j]),
            .str_in  (ch_str[j]),
            .vld_out (ch_vld[j+1]),
            .idx_out (ch_idx[j+1]),
            .res_out (ch_res[j+1]),
            .str_out (ch_str[j+1])
         );
      end
   endgenerate

   assign last_vld              = ch_vld[MAX_RANK];
   assign rsp_word.valid        = last_vld;
   assign rsp_word.source_index = ch_res[MAX_RANK];

endmodule

`default_nettype wire
